>>> design/isp_pkg.sv
package isp_pkg;

   localparam int COUNTER_WIDTH = 32;

   localparam int BYTE_W      = 8;
   localparam int RAW_W       = 16;
   localparam int FS_W        = 12;
   localparam int AXIS_W      = 28;
   localparam int TOTAL_W     = 32;
   localparam int POS_W       = 4;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = FS_W;
   localparam int AXIS_BYTES  = 6;
   localparam int AXIS_IDX_W  = $clog2(AXIS_BYTES);
   localparam int PROD_W      = RAW_W + FS_W + 1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [BYTE_W-1:0] HDR_BYTE   = 8'h55;
   localparam logic [BYTE_W-1:0] TYPE_RATE  = 8'h52;
   localparam logic [BYTE_W-1:0] TYPE_ANGLE = 8'h53;

   // positions within an 11-byte frame
   localparam logic [POS_W-1:0] POS_AXIS_FIRST = 4'd2;
   localparam logic [POS_W-1:0] POS_AXIS_END   = 4'd8;
   localparam logic [POS_W-1:0] POS_CHECKSUM   = 4'd10;

   localparam logic [FS_W-1:0] ANGLE_FS_RESET = 12'd180;
   localparam logic [FS_W-1:0] RATE_FS_RESET  = 12'd2000;

   typedef enum logic [1:0] {
      PHASE_HUNT = 2'd0,
      PHASE_TYPE = 2'd1,
      PHASE_BODY = 2'd2
   } phase_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_ANGLE_OK = 2'd0,
      STATUS_RATE_OK  = 2'd1,
      STATUS_BAD_SUM  = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ANGLE_FS = 1'b0,
      CSR_RATE_FS  = 1'b1
   } csr_index_type;

   // one finished frame as handed from parser to scaler
   typedef struct packed {
      logic                    sum_ok;
      logic                    is_angle;
      logic signed [RAW_W-1:0] raw_x;
      logic signed [RAW_W-1:0] raw_y;
      logic signed [RAW_W-1:0] raw_z;
   } packet_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

>>> design/isp_req_if.sv
interface isp_req_if
   import isp_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> design/isp_rsp_if.sv
interface isp_rsp_if
   import isp_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic signed [AXIS_W-1:0] axis_x;
   logic signed [AXIS_W-1:0] axis_y;
   logic signed [AXIS_W-1:0] axis_z;
   logic [TOTAL_W-1:0]       good_total;
   logic [TOTAL_W-1:0]       bad_total;
   logic [TOTAL_W-1:0]       angle_total;
   logic [TOTAL_W-1:0]       rate_total;

   modport source (output valid, output status, output axis_x, output axis_y,
                   output axis_z, output good_total, output bad_total,
                   output angle_total, output rate_total, input ready);
   modport sink   (input valid, input status, input axis_x, input axis_y,
                   input axis_z, input good_total, input bad_total,
                   input angle_total, input rate_total, output ready);
endinterface

>>> design/isp_front.sv
module isp_front
   import isp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   isp_req_if.sink          req_chan,
   input  queue_status_type q_status,
   output logic             push,
   output packet_type       push_data
);

   phase_type              phase_ff, phase_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [BYTE_W-1:0]      sum_ff, sum_in;
   logic                   angle_ff, angle_in;
   logic [BYTE_W-1:0]      axis_ff [AXIS_BYTES];
   logic                   axis_wr;
   logic [AXIS_IDX_W-1:0]  axis_idx;
   logic [POS_W-1:0]       axis_off;
   logic                   take;
   logic [BYTE_W-1:0]      b;

   assign req_chan.ready = !q_status.full;
   assign take           = req_chan.valid && req_chan.ready;
   assign b              = req_chan.rx_byte;
   assign axis_off       = pos_ff - POS_AXIS_FIRST;
   assign axis_idx       = axis_off[AXIS_IDX_W-1:0];

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      sum_in   = sum_ff;
      angle_in = angle_ff;
      axis_wr  = 1'b0;
      push     = 1'b0;
      if (take) begin
         unique case (phase_ff)
            PHASE_TYPE: begin
               if (b == TYPE_RATE || b == TYPE_ANGLE) begin
                  angle_in = (b == TYPE_ANGLE);
                  sum_in   = sum_ff + b;
                  pos_in   = POS_AXIS_FIRST;
                  phase_in = PHASE_BODY;
               end else begin
                  // wrong type: back to the hunt, this byte is not checked as a header
                  phase_in = PHASE_HUNT;
                  pos_in   = '0;
                  sum_in   = '0;
               end
            end
            PHASE_BODY: begin
               if (pos_ff < POS_CHECKSUM) begin
                  axis_wr = (pos_ff >= POS_AXIS_FIRST) && (pos_ff < POS_AXIS_END);
                  sum_in  = sum_ff + b;
                  pos_in  = pos_ff + 1'b1;
               end else begin
                  push     = 1'b1;
                  phase_in = PHASE_HUNT;
                  pos_in   = '0;
                  sum_in   = '0;
                  angle_in = 1'b0;
               end
            end
            default: begin
               if (b == HDR_BYTE) begin
                  sum_in   = b;
                  pos_in   = 4'd1;
                  phase_in = PHASE_TYPE;
               end else begin
                  phase_in = PHASE_HUNT;
                  pos_in   = '0;
                  sum_in   = '0;
               end
            end
         endcase
      end
   end

   always_comb begin
      push_data.sum_ok   = (b == sum_ff);
      push_data.is_angle = angle_ff;
      push_data.raw_x    = {axis_ff[1], axis_ff[0]};
      push_data.raw_y    = {axis_ff[3], axis_ff[2]};
      push_data.raw_z    = {axis_ff[5], axis_ff[4]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_HUNT;
         pos_ff   <= '0;
         sum_ff   <= '0;
         angle_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         sum_ff   <= sum_in;
         angle_ff <= angle_in;
      end
   end

   always_ff @(posedge clock) begin
      if (axis_wr) begin
         axis_ff[axis_idx] <= b;
      end
   end

endmodule

>>> design/isp_queue.sv
module isp_queue
   import isp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  packet_type       push_data,
   input  logic             pop,
   output packet_type       pop_data,
   output queue_status_type q_status
);

   packet_type             mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign q_status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_push        = push && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign pop_data       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> design/isp_back.sv
module isp_back
   import isp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data,
   input  queue_status_type       q_status,
   input  packet_type             pop_data,
   output logic                   pop,
   isp_rsp_if.source              rsp_chan
);

   logic [FS_W-1:0]          angle_fs_ff, rate_fs_ff;
   logic [FS_W-1:0]          fs;
   logic signed [FS_W:0]     fs_s;
   logic signed [PROD_W-1:0] prod_x, prod_y, prod_z;

   logic [COUNTER_WIDTH-1:0] good_ff, good_in;
   logic [COUNTER_WIDTH-1:0] bad_ff, bad_in;
   logic [COUNTER_WIDTH-1:0] angle_ff, angle_in;
   logic [COUNTER_WIDTH-1:0] rate_ff, rate_in;

   logic                     valid_ff;
   status_type               status_ff, status_in;
   logic signed [AXIS_W-1:0] x_ff, y_ff, z_ff, x_in, y_in, z_in;
   logic [TOTAL_W-1:0]       good_tot_ff, bad_tot_ff, angle_tot_ff, rate_tot_ff;

   // take from the queue when the output register is empty or draining
   assign pop = !q_status.empty && (!valid_ff || rsp_chan.ready);

   assign fs     = pop_data.is_angle ? angle_fs_ff : rate_fs_ff;
   assign fs_s   = $signed({1'b0, fs});
   assign prod_x = pop_data.raw_x * fs_s;
   assign prod_y = pop_data.raw_y * fs_s;
   assign prod_z = pop_data.raw_z * fs_s;

   always_comb begin
      good_in  = good_ff;
      bad_in   = bad_ff;
      angle_in = angle_ff;
      rate_in  = rate_ff;
      if (pop_data.sum_ok) begin
         status_in = pop_data.is_angle ? STATUS_ANGLE_OK : STATUS_RATE_OK;
         x_in      = $signed(prod_x[AXIS_W-1:0]);
         y_in      = $signed(prod_y[AXIS_W-1:0]);
         z_in      = $signed(prod_z[AXIS_W-1:0]);
         good_in   = good_ff + 1'b1;
         if (pop_data.is_angle) begin
            angle_in = angle_ff + 1'b1;
         end else begin
            rate_in = rate_ff + 1'b1;
         end
      end else begin
         status_in = STATUS_BAD_SUM;
         x_in      = '0;
         y_in      = '0;
         z_in      = '0;
         bad_in    = bad_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_fs_ff <= ANGLE_FS_RESET;
         rate_fs_ff  <= RATE_FS_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_ANGLE_FS: angle_fs_ff <= csr_wr_data;
            CSR_RATE_FS:  rate_fs_ff  <= csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         good_ff  <= '0;
         bad_ff   <= '0;
         angle_ff <= '0;
         rate_ff  <= '0;
      end else begin
         if (pop) begin
            valid_ff <= 1'b1;
            good_ff  <= good_in;
            bad_ff   <= bad_in;
            angle_ff <= angle_in;
            rate_ff  <= rate_in;
         end else if (rsp_chan.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         status_ff    <= status_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         z_ff         <= z_in;
         good_tot_ff  <= TOTAL_W'(good_in);
         bad_tot_ff   <= TOTAL_W'(bad_in);
         angle_tot_ff <= TOTAL_W'(angle_in);
         rate_tot_ff  <= TOTAL_W'(rate_in);
      end
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.status      = status_ff;
   assign rsp_chan.axis_x      = x_ff;
   assign rsp_chan.axis_y      = y_ff;
   assign rsp_chan.axis_z      = z_ff;
   assign rsp_chan.good_total  = good_tot_ff;
   assign rsp_chan.bad_total   = bad_tot_ff;
   assign rsp_chan.angle_total = angle_tot_ff;
   assign rsp_chan.rate_total  = rate_tot_ff;

endmodule

>>> design/imu_serial_packet_parser_unit.sv
// channel    dir  handshake      word carries
// ---------  ---  -------------  -----------------------------------------------
// req_chan   in   valid/ready    rx_byte: one serial byte
// rsp_chan   out  valid/ready    status, axis_x/y/z, good/bad/angle/rate totals
// csr_*      in   write enable   csr_index selects angle or rate full scale
//
// One byte is taken every cycle; the parser front end finishes each byte in
// the cycle it is taken, so ready drops only while the two-entry frame queue
// is full. Taking the checksum byte writes the frame into the queue; the
// scaling multipliers then feed the output register once it is empty or
// draining, and the result is valid from that register.
// Reset clears parser state, queue pointers, counters and the output valid;
// full-scale registers return to 180 and 2000.
// A stalled rsp_chan holds its word; the queue absorbs up to two more frames.
module imu_serial_packet_parser_unit
   import isp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   isp_req_if.sink                req_chan,
   isp_rsp_if.source              rsp_chan,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data
);

   // frame descriptor from parser to scaler
   packet_type       push_data;
   packet_type       pop_data;
   logic             push;
   logic             pop;
   queue_status_type q_status;

   // front end: hunt for header, check type, run checksum, collect axis bytes
   isp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   // decouple the parser from output backpressure
   isp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .q_status  (q_status)
   );

   // back end: scale axes by full scale, advance counters, hold result word
   isp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .q_status    (q_status),
      .pop_data    (pop_data),
      .pop         (pop),
      .rsp_chan    (rsp_chan)
   );

endmodule

>>> design/isp_checker.sv
module isp_checker
   import isp_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [STATUS_W-1:0]      rsp_status,
   input logic signed [AXIS_W-1:0] rsp_axis_x,
   input logic signed [AXIS_W-1:0] rsp_axis_y,
   input logic signed [AXIS_W-1:0] rsp_axis_z,
   input logic [TOTAL_W-1:0]       rsp_bad_total
);

   // no result word right after reset
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_ANGLE_OK || rsp_status == STATUS_RATE_OK ||
                     rsp_status == STATUS_BAD_SUM))
      else $error("unused status code");

   a_bad_zero_axes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_BAD_SUM |->
         rsp_axis_x == '0 && rsp_axis_y == '0 && rsp_axis_z == '0)
      else $error("checksum error with nonzero axes");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_axis_x) && $stable(rsp_bad_total))
      else $error("stalled result word changed");

endmodule

bind imu_serial_packet_parser_unit isp_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_status    (rsp_chan.status),
   .rsp_axis_x    (rsp_chan.axis_x),
   .rsp_axis_y    (rsp_chan.axis_y),
   .rsp_axis_z    (rsp_chan.axis_z),
   .rsp_bad_total (rsp_chan.bad_total)
);
